// ===== sv/aics_pkg.sv =====
// Package for the arcade input coin scanner: request types, function codes,
// pin masks and the player swap shuffles. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aics_pkg;

  typedef enum logic [2:0] {
    FUNC_SAMPLE = 3'd0,
    FUNC_SYNC   = 3'd1,
    FUNC_ADD    = 3'd2,
    FUNC_SUB    = 3'd3,
    FUNC_READ   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    REG_SWAP_PLAYERS = 2'd0,
    REG_SWAP_VARIANT = 2'd1,
    REG_RAPID_ENABLE = 2'd2
  } reg_index_e;

  localparam int unsigned NumSwitch = 5;
  localparam int unsigned NumCoin   = 2;

  localparam logic [7:0] SwTwoP4Mask  = 8'hb0;
  localparam logic [7:0] SwTwoP1Mask  = 8'h40;
  localparam logic [7:0] SwThreeMask  = 8'hbf;
  localparam logic [7:0] SwFourMask   = 8'hf0;
  localparam logic [7:0] TestBitValue = 8'h80;
  localparam logic [1:0] CoinIdle     = 2'b11;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] port_zero;
    logic [7:0] port_one;
    logic [7:0] port_three;
    logic [7:0] port_four;
    logic       rapid_off;
    logic       coin_index;
    logic [7:0] coin_amount;
  } in_req_t;

  typedef struct packed {
    logic [7:0] switch_zero;
    logic [7:0] switch_one;
    logic [7:0] switch_two;
    logic [7:0] switch_three;
    logic [7:0] switch_four;
    logic [7:0] coins_first;
    logic [7:0] coins_second;
  } out_req_t;

  typedef struct packed {
    logic [1:0] reg_index;
    logic       wdata;
  } cfg_req_t;

  // Default shuffle of a byte pair: returns {new_lo, new_hi}.
  function automatic logic [15:0] shuffle_default(input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] na;
    logic [7:0] nb;
    na = {lo[7:2], hi[6], lo[1]};
    nb = {lo[0], hi[7:1]};
    return {na, nb};
  endfunction

  // Alternate shuffle of a byte pair: returns {new_lo, new_hi}.
  function automatic logic [15:0] shuffle_alt(input logic [7:0] lo, input logic [7:0] hi);
    logic [7:0] na;
    logic [7:0] nb;
    na = {lo[7:2], lo[0], hi[7]};
    nb = {hi[6], hi[5] | lo[1], hi[4:0], 1'b0};
    return {na, nb};
  endfunction

endpackage

`default_nettype wire

// ===== sv/aics_if.sv =====
// Valid/ready channel interfaces of the coin scanner (input, result, config).
// Depends on aics_pkg for the request types.
`timescale 1ns / 1ps
`default_nettype none

interface aics_in_if;
  logic              valid;
  logic              ready;
  aics_pkg::in_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aics_out_if;
  logic               valid;
  logic               ready;
  aics_pkg::out_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface aics_cfg_if;
  logic               valid;
  logic               ready;
  aics_pkg::cfg_req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/arcade_input_coin_scanner_core.sv =====
// A request accepted at a clock edge has its result registered and valid in the next cycle.
// Throughput: one request per cycle while results are taken; the result register frees up as it is taken.
// Reset (rst_ni, async, active low): config clear, switch bytes and counters zero,
// coin levels high, result register empty. Config writes are taken every cycle.
// Depends on aics_pkg and the channel interfaces in aics_if.sv.
`timescale 1ns / 1ps
`default_nettype none

module arcade_input_coin_scanner_core (
  input  wire        clk_i,
  input  wire        rst_ni,
  aics_in_if.sink    in_i,
  aics_cfg_if.sink   cfg_i,
  aics_out_if.source out_o
);
  import aics_pkg::*;

  // Config registers
  logic swap_q, alt_q, rapid_q;

  // Scanner state
  logic [7:0] sw_q  [NumSwitch];
  logic [7:0] sw_d  [NumSwitch];
  logic [1:0] win_q, win_d;    // AND of coin lines over the open window
  logic [1:0] prev_q, prev_d;  // level seen in the previous window
  logic [7:0] cnt_q [NumCoin];
  logic [7:0] cnt_d [NumCoin];

  // Result register
  logic     out_valid_q;
  out_req_t out_q, out_d;

  logic in_acc, cfg_acc, out_acc;
  in_req_t req;

  // The result register doubles as the skid point: a new request goes in as
  // the waiting result leaves.
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid;
  assign out_acc     = out_valid_q && out_o.ready;
  assign req         = in_i.payload;

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // ---------------------------------------------------------------------
  // Next state for one request
  // ---------------------------------------------------------------------
  logic [7:0]  raw  [NumSwitch];
  logic [15:0] pr_a, pr_b;

  // Pin remap, active low in, active high out
  always_comb begin
    raw[0] = req.port_four[2] ? 8'h00 : TestBitValue;
    raw[1] = ~req.port_three;
    raw[2] = (~req.port_four & SwTwoP4Mask) | (~req.port_one & SwTwoP1Mask);
    raw[3] = ~req.port_one & SwThreeMask;
    raw[4] = ~req.port_zero & SwFourMask;
    if (alt_q) begin
      pr_a = shuffle_alt(raw[1], raw[2]);
      pr_b = shuffle_alt(raw[3], raw[4]);
    end else begin
      pr_a = shuffle_default(raw[1], raw[2]);
      pr_b = shuffle_default(raw[3], raw[4]);
    end
  end

  always_comb begin
    for (int i = 0; i < NumSwitch; i++) begin
      sw_d[i] = sw_q[i];
    end
    for (int i = 0; i < NumCoin; i++) begin
      cnt_d[i] = cnt_q[i];
    end
    win_d  = win_q;
    prev_d = prev_q;
    case (func_e'(req.func))
      FUNC_SAMPLE: begin
        win_d   = win_q & req.port_four[1:0];
        sw_d[0] = raw[0];
        if (swap_q) begin
          sw_d[1] = pr_a[15:8];
          sw_d[2] = pr_a[7:0];
          sw_d[3] = pr_b[15:8];
          sw_d[4] = pr_b[7:0];
        end else begin
          sw_d[1] = raw[1];
          sw_d[2] = raw[2];
          sw_d[3] = raw[3];
          sw_d[4] = raw[4];
        end
      end
      FUNC_SYNC: begin
        // count a rising edge of the window level
        for (int i = 0; i < NumCoin; i++) begin
          if (!prev_q[i] && win_q[i]) begin
            cnt_d[i] = cnt_q[i] + 8'd1;
          end
        end
        prev_d = win_q;
        win_d  = CoinIdle;
      end
      FUNC_ADD: begin
        cnt_d[req.coin_index] = cnt_q[req.coin_index] + req.coin_amount;
      end
      FUNC_SUB: begin
        cnt_d[req.coin_index] = cnt_q[req.coin_index] - req.coin_amount;
      end
      default: begin
        // read only, unused codes too
      end
    endcase
  end

  // Report after the update, rapid bits merged when enabled unless masked
  logic merge;
  assign merge = rapid_q && !req.rapid_off;

  always_comb begin
    out_d.switch_zero  = sw_d[0];
    out_d.switch_one   = sw_d[1];
    out_d.switch_two   = sw_d[2];
    out_d.switch_three = sw_d[3];
    out_d.switch_four  = sw_d[4];
    if (merge) begin
      out_d.switch_one   = sw_d[1] | {6'd0, sw_d[2][6:5]};
      out_d.switch_two   = sw_d[2] | {sw_d[2][4], 7'd0};
      out_d.switch_three = sw_d[3] | {6'd0, sw_d[4][6:5]};
      out_d.switch_four  = sw_d[4] | {sw_d[4][4], 7'd0};
    end
    out_d.coins_first  = cnt_d[0];
    out_d.coins_second = cnt_d[1];
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q  <= 1'b0;
      alt_q   <= 1'b0;
      rapid_q <= 1'b0;
    end else if (cfg_acc) begin
      case (reg_index_e'(cfg_i.payload.reg_index))
        REG_SWAP_PLAYERS: swap_q  <= cfg_i.payload.wdata;
        REG_SWAP_VARIANT: alt_q   <= cfg_i.payload.wdata;
        REG_RAPID_ENABLE: rapid_q <= cfg_i.payload.wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSwitch; i++) begin
        sw_q[i] <= 8'h00;
      end
      for (int i = 0; i < NumCoin; i++) begin
        cnt_q[i] <= 8'h00;
      end
      win_q  <= CoinIdle;
      prev_q <= CoinIdle;
    end else if (in_acc) begin
      sw_q   <= sw_d;
      cnt_q  <= cnt_d;
      win_q  <= win_d;
      prev_q <= prev_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTHESIS
  // Any accepted request leaves a result waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> out_valid_q)
    else $error("no result after accepted request");

  // An empty result register must never block the input
  assert property (@(posedge clk_i) disable iff (!rst_ni) !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");

  // A sync reopens the window with both lines high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && req.func == FUNC_SYNC) |=> (win_q == CoinIdle))
    else $error("coin window not reopened on sync");

  // Counters move only on sync, add or subtract
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_acc || (req.func != FUNC_SYNC && req.func != FUNC_ADD && req.func != FUNC_SUB))
    |=> ($stable(cnt_q[0]) && $stable(cnt_q[1])))
    else $error("coin counter changed without a counting request");
`endif

endmodule

`default_nettype wire

// ===== tb/arcade_input_coin_scanner_core_tb.sv =====
// Self-checking testbench for arcade_input_coin_scanner_core: random and directed
// requests on the valid/ready channels, checked against an in-bench predictor.
// Depends on aics_pkg and the channel interfaces in aics_if.sv.
`timescale 1ns / 1ps

module arcade_input_coin_scanner_core_tb;
  import aics_pkg::*;

  localparam int unsigned CycleLimit  = 100000;
  localparam int unsigned PhaseLength = 80;
  localparam logic [2:0] FuncSpareLo = 3'd5;  // codes above read only, treated as read
  localparam logic [2:0] FuncSpareHi = 3'd7;
  localparam logic [1:0] RegUnused   = 2'd3;  // index with no register behind it

  // Predictor plus expected-report store. One report per request, in order.
  class coin_scanner_scoreboard;
    bit         swap_on, alt_on, rapid_on;
    bit [7:0]   switch_state [NumSwitch];
    bit         coin_window_high [NumCoin];
    bit         coin_last_high [NumCoin];
    bit [7:0]   coin_total [NumCoin];
    out_req_t   expected_reports [$];
    int unsigned errors, accepted, samples, syncs, coin_edges, adjusts;

    function new();
      for (int i = 0; i < NumSwitch; i++) switch_state[i] = '0;
      for (int i = 0; i < NumCoin; i++) begin
        coin_window_high[i] = 1'b1;
        coin_last_high[i]   = 1'b1;
        coin_total[i]       = '0;
      end
    endfunction

    function void set_register(logic [1:0] idx, logic val);
      case (idx)
        REG_SWAP_PLAYERS: swap_on  = val;
        REG_SWAP_VARIANT: alt_on   = val;
        REG_RAPID_ENABLE: rapid_on = val;
        default: ;
      endcase
    endfunction

    // Player swap on one byte pair (first/second switch byte of a player).
    function void swap_pair(inout bit [7:0] lo, inout bit [7:0] hi);
      bit [7:0] nlo, nhi;
      if (alt_on) begin
        nlo = {lo[7:2], lo[0], hi[7]};
        nhi = {hi[6:0], 1'b0} | ({7'd0, lo[1]} << 6);
      end else begin
        nlo = {lo[7:2], hi[6], lo[1]};
        nhi = {lo[0], hi[7:1]};
      end
      lo = nlo;
      hi = nhi;
    endfunction

    function void note_request(in_req_t r);
      out_req_t  rep;
      bit [7:0]  sw [NumSwitch];
      accepted++;
      case (r.func)
        FUNC_SAMPLE: begin
          samples++;
          for (int c = 0; c < NumCoin; c++)
            coin_window_high[c] &= r.port_four[c];
          switch_state[0] = r.port_four[2] ? 8'h00 : TestBitValue;
          switch_state[1] = ~r.port_three;
          switch_state[2] = (~r.port_four & SwTwoP4Mask) | (~r.port_one & SwTwoP1Mask);
          switch_state[3] = ~r.port_one & SwThreeMask;
          switch_state[4] = ~r.port_zero & SwFourMask;
          if (swap_on) begin
            swap_pair(switch_state[1], switch_state[2]);
            swap_pair(switch_state[3], switch_state[4]);
          end
        end
        FUNC_SYNC: begin
          syncs++;
          for (int c = 0; c < NumCoin; c++) begin
            // rising edge between windows counts one coin
            if (!coin_last_high[c] && coin_window_high[c]) begin
              coin_total[c]++;
              coin_edges++;
            end
            coin_last_high[c]   = coin_window_high[c];
            coin_window_high[c] = 1'b1;
          end
        end
        FUNC_ADD: begin
          adjusts++;
          coin_total[r.coin_index] += r.coin_amount;
        end
        FUNC_SUB: begin
          adjusts++;
          coin_total[r.coin_index] -= r.coin_amount;
        end
        default: ;
      endcase
      for (int i = 0; i < NumSwitch; i++) sw[i] = switch_state[i];
      // rapid-fire merge touches the report only, never the stored bytes
      if (rapid_on && !r.rapid_off) begin
        sw[1][1:0] |= switch_state[2][6:5];
        sw[3][1:0] |= switch_state[4][6:5];
        sw[2][7]   |= switch_state[2][4];
        sw[4][7]   |= switch_state[4][4];
      end
      rep.switch_zero  = sw[0];
      rep.switch_one   = sw[1];
      rep.switch_two   = sw[2];
      rep.switch_three = sw[3];
      rep.switch_four  = sw[4];
      rep.coins_first  = coin_total[0];
      rep.coins_second = coin_total[1];
      expected_reports.push_back(rep);
    endfunction

    function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      end
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $error("report with no request outstanding: 0x%014h", got);
        return;
      end
      want = expected_reports.pop_front();
      check_field("switch_zero",  want.switch_zero,  got.switch_zero);
      check_field("switch_one",   want.switch_one,   got.switch_one);
      check_field("switch_two",   want.switch_two,   got.switch_two);
      check_field("switch_three", want.switch_three, got.switch_three);
      check_field("switch_four",  want.switch_four,  got.switch_four);
      check_field("coins_first",  want.coins_first,  got.coins_first);
      check_field("coins_second", want.coins_second, got.coins_second);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;   // set: neither side idles
  int unsigned cycles = 0;
  int unsigned phases = 0;

  aics_in_if  in_ch ();
  aics_cfg_if cfg_ch ();
  aics_out_if out_ch ();

  coin_scanner_scoreboard sb = new();

  arcade_input_coin_scanner_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** arcade_input_coin_scanner_core: FAILED **");
      $finish;
    end
  end

  // Alternate stretches of random idling with stretches of none.
  initial begin
    forever begin
      repeat ($urandom_range(20, 150)) @(posedge clk_i);
      steady = ~steady;
    end
  end

  // Result side: random stalls on ready, check every report taken.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      sb.check_result(out_ch.payload);
    end
  end

  function automatic in_req_t make_request(logic [2:0] func, logic [7:0] p0, logic [7:0] p1,
                                           logic [7:0] p3, logic [7:0] p4, logic mask,
                                           logic idx, logic [7:0] amount);
    in_req_t r;
    r.func        = func;
    r.port_zero   = p0;
    r.port_one    = p1;
    r.port_three  = p3;
    r.port_four   = p4;
    r.rapid_off   = mask;
    r.coin_index  = idx;
    r.coin_amount = amount;
    return r;
  endfunction

  function automatic in_req_t random_request();
    return make_request(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        8'($urandom));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_request(input in_req_t req);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.payload <= req;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_request(req);
    @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding report drain.
  task automatic drain_requests();
    in_ch.valid <= 1'b0;
    while (sb.expected_reports.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_register(logic [1:0] idx, logic val);
    cfg_req_t w;
    w.reg_index = idx;
    w.wdata     = val;
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= w;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    sb.set_register(idx, val);
    @(negedge clk_i);
  endtask

  // Well-formed coin window: a few samples with each coin either held high
  // or pulled low at least once, odd counter traffic mixed in, then a sync.
  task automatic send_coin_window();
    int unsigned n_samples;
    int unsigned s;
    int unsigned c;
    bit          hold_high [NumCoin];
    in_req_t     req;
    n_samples = $urandom_range(1, 4);
    for (c = 0; c < NumCoin; c++) hold_high[c] = 1'($urandom_range(0, 1));
    for (s = 0; s < n_samples; s++) begin
      req = random_request();
      req.func = FUNC_SAMPLE;
      for (c = 0; c < NumCoin; c++) begin
        if (hold_high[c]) req.port_four[c] = 1'b1;
        else if (s == 0)  req.port_four[c] = 1'b0;
      end
      push_request(req);
      if ($urandom_range(0, 5) == 0) begin
        req = random_request();
        case ($urandom_range(0, 2))
          0:       req.func = FUNC_ADD;
          1:       req.func = FUNC_SUB;
          default: req.func = FUNC_READ;
        endcase
        push_request(req);
      end
    end
    req = random_request();
    req.func = FUNC_SYNC;
    push_request(req);
  endtask

  initial begin
    // settings as {swap_players, swap variant, rapid_enable}; extremes first
    logic [2:0]  settings [8];
    int unsigned start;
    int unsigned k;
    in_req_t     req;

    settings = '{3'b000, 3'b111, 3'b100, 3'b110,
                 3'b001, 3'b101, 3'b011, 3'b010};
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part, reset configuration.
    push_request(make_request(FUNC_READ, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
    push_request(make_request(FUNC_SAMPLE, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'hff));
    push_request(make_request(FUNC_SAMPLE, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00));
    // window was low: no count, last level goes low
    push_request(make_request(FUNC_SYNC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h7f));
    push_request(make_request(FUNC_SAMPLE, 8'h5a, 8'ha5, 8'h3c, 8'hff, 1'b0, 1'b0, 8'h00));
    // low-to-high across windows: both slots count
    push_request(make_request(FUNC_SYNC, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1, 1'b0, 8'h00));
    push_request(make_request(FUNC_SAMPLE, 8'ha5, 8'h5a, 8'hc3, 8'hfe, 1'b0, 1'b0, 8'h00));
    push_request(make_request(FUNC_SYNC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
    // empty window reads high: the first slot counts again
    push_request(make_request(FUNC_SYNC, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
    // counter wrap both ways, operands ignored on the other functions
    push_request(make_request(FUNC_ADD, 8'hff, 8'hff, 8'hff, 8'h00, 1'b0, 1'b0, 8'hff));
    push_request(make_request(FUNC_SUB, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h02));
    push_request(make_request(FUNC_ADD, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00));
    push_request(make_request(FUNC_SUB, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'hff));
    push_request(make_request(FUNC_ADD, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0, 1'b1, 8'h80));
    for (k = FuncSpareLo; k <= FuncSpareHi; k++)
      push_request(make_request(3'(k), 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), k[0], k[1], 8'hff));
    // test button both ways
    push_request(make_request(FUNC_SAMPLE, 8'h0f, 8'hf0, 8'h00, 8'hfb, 1'b0, 1'b0, 8'h00));
    push_request(make_request(FUNC_SAMPLE, 8'hf0, 8'h0f, 8'hff, 8'h04, 1'b1, 1'b1, 8'h01));
    push_request(make_request(FUNC_READ, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
    push_request(make_request(FUNC_READ, 8'hff, 8'hff, 8'hff, 8'hff, 1'b0, 1'b1, 8'hff));
    drain_requests();

    // Random phases, one per register setting.
    foreach (settings[p]) begin
      write_register(REG_SWAP_PLAYERS, settings[p][2]);
      write_register(REG_SWAP_VARIANT, settings[p][1]);
      write_register(REG_RAPID_ENABLE, settings[p][0]);
      if (p == 3) write_register(RegUnused, 1'b1);   // must leave all registers alone
      cfg_ch.valid <= 1'b0;
      phases++;
      start = sb.accepted;
      while (sb.accepted - start < PhaseLength) begin
        if ($urandom_range(0, 3) != 0) begin
          send_coin_window();
        end else begin
          req = random_request();
          push_request(req);
        end
      end
      drain_requests();
    end

    repeat (5) @(posedge clk_i);
    if (sb.expected_reports.size() != 0) begin
      sb.errors++;
      $error("%0d reports never arrived", sb.expected_reports.size());
    end
    $display("Run: %0d requests over %0d register settings; %0d samples, %0d syncs,",
             sb.accepted, phases, sb.samples, sb.syncs);
    $display("     %0d coins counted on window edges, %0d counter adjustments, %0d errors",
             sb.coin_edges, sb.adjusts, sb.errors);
    if (sb.errors == 0) begin
      $display("** arcade_input_coin_scanner_core: PASSED **");
    end else begin
      $display("** arcade_input_coin_scanner_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/aics_pkg.sv
sv/aics_if.sv
sv/arcade_input_coin_scanner_core.sv
tb/arcade_input_coin_scanner_core_tb.sv
